// ===== hdl/sepd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sepd_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 16;

  // datapath widths, all derived from the two sizes above
  localparam int SQ_W  = 2 * SAMPLE_BITS;       // square of one input part
  localparam int A_W   = SQ_W + 2;              // sum of the four channel energies
  localparam int S_W   = SAMPLE_BITS + 1;       // one part of L + R
  localparam int SSQ_W = 2 * S_W;               // square of one sum part
  localparam int B_W   = SSQ_W + 1;             // |S|^2
  localparam int D_W   = B_W + 2;               // divisor 4 * |S|^2
  localparam int R_W   = D_W + 1;               // partial remainder
  localparam int Q_W   = 2 * GAIN_FRAC_BITS + 2; // squared gain quotient
  localparam int G_W   = GAIN_FRAC_BITS + 2;    // gain, limit 2.0 included
  localparam int M_W   = S_W + G_W;             // scaled magnitude

  localparam int N_STG = 4 + Q_W + (GAIN_FRAC_BITS + 1) + 2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mono_re;
    logic [SAMPLE_BITS-1:0] mono_im;
    logic                   gain_limited;
    logic                   saturated;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/sepd_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sepd_in_if;
  import sepd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_re;
  logic [SAMPLE_BITS-1:0] left_im;
  logic [SAMPLE_BITS-1:0] right_re;
  logic [SAMPLE_BITS-1:0] right_im;

  modport source (output valid, left_re, left_im, right_re, right_im, input ready);
  modport sink   (input valid, left_re, left_im, right_re, right_im, output ready);
endinterface
`default_nettype wire

// ===== hdl/sepd_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sepd_out_if;
  import sepd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] mono_re;
  logic [SAMPLE_BITS-1:0] mono_im;
  logic                   gain_limited;
  logic                   saturated;

  modport source (output valid, mono_re, mono_im, gain_limited, saturated, input ready);
  modport sink   (input valid, mono_re, mono_im, gain_limited, saturated, output ready);
endinterface
`default_nettype wire

// ===== hdl/stereo_energy_preserving_downmix_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Energy-preserving stereo downmix: each complex (left, right) sample pair gives one
// mono sample (L + R) * g, g = sqrt(((|L|^2+|R|^2)/2) / |S|^2) truncated to 16 fractional
// bits and limited to 2.0, rounded half away from zero and saturated to 24 bits.
// One item is taken per clock while the output skid register is empty; the pipe runs
// through a bit-serial divider (one quotient bit per stage) and square root (one root
// bit per stage) to the output register. Input ready depends only on the output skid
// register, never combinationally on output ready.
module stereo_energy_preserving_downmix_top
  import sepd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sepd_in_if.sink    in_i,
  sepd_out_if.source out_o
);

  localparam int F = GAIN_FRAC_BITS;

  logic en;
  logic in_fire;
  logic [N_STG-1:0] vld_q;

  // stage 1: sums and input squares
  logic [SQ_W-1:0]        sq_q [4];
  logic signed [S_W-1:0]  s1_sr_q, s1_si_q;
  // stage 2
  logic [A_W-1:0]         s2_a_q;
  logic [SSQ_W-1:0]       s2_ssr_q, s2_ssi_q;
  logic signed [S_W-1:0]  s2_sr_q, s2_si_q;
  // stage 3
  logic [A_W-1:0]         s3_a_q;
  logic [B_W-1:0]         s3_b_q;
  logic signed [S_W-1:0]  s3_sr_q, s3_si_q;

  // divider chain, index 0 is loaded by stage 4
  logic [R_W-1:0]         dv_r_q   [Q_W+1];
  logic [D_W-1:0]         dv_d_q   [Q_W+1];
  logic [Q_W-1:0]         dv_q_q   [Q_W+1];
  logic                   dv_lim_q [Q_W+1];
  logic signed [S_W-1:0]  dv_sr_q  [Q_W+1];
  logic signed [S_W-1:0]  dv_si_q  [Q_W+1];

  // root chain, index 0 is the divider output
  logic [Q_W-1:0]         rt_r   [F+2];
  logic [F:0]             rt_g   [F+2];
  logic                   rt_lim [F+2];
  logic signed [S_W-1:0]  rt_sr  [F+2];
  logic signed [S_W-1:0]  rt_si  [F+2];

  // product and final stage
  logic [M_W-1:0]         pm_re_q, pm_im_q;
  logic                   pm_nre_q, pm_nim_q, pm_lim_q;
  res_t                   fin_q;

  // output register and skid
  res_t                   out_q, skd_q;
  logic                   out_v_q, skd_v_q;

  assign en       = !skd_v_q;
  assign in_i.ready = en;
  assign in_fire  = in_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_STG-2:0], in_fire};
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q[0] <= SQ_W'($signed(in_i.left_re)  * $signed(in_i.left_re));
      sq_q[1] <= SQ_W'($signed(in_i.left_im)  * $signed(in_i.left_im));
      sq_q[2] <= SQ_W'($signed(in_i.right_re) * $signed(in_i.right_re));
      sq_q[3] <= SQ_W'($signed(in_i.right_im) * $signed(in_i.right_im));
      s1_sr_q <= $signed({in_i.left_re[SAMPLE_BITS-1], in_i.left_re})
               + $signed({in_i.right_re[SAMPLE_BITS-1], in_i.right_re});
      s1_si_q <= $signed({in_i.left_im[SAMPLE_BITS-1], in_i.left_im})
               + $signed({in_i.right_im[SAMPLE_BITS-1], in_i.right_im});
    end
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_a_q   <= A_W'(sq_q[0]) + A_W'(sq_q[1]) + A_W'(sq_q[2]) + A_W'(sq_q[3]);
      s2_ssr_q <= SSQ_W'(s1_sr_q * s1_sr_q);
      s2_ssi_q <= SSQ_W'(s1_si_q * s1_si_q);
      s2_sr_q  <= s1_sr_q;
      s2_si_q  <= s1_si_q;
    end
  end

  // stage 3
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_a_q  <= s2_a_q;
      s3_b_q  <= B_W'(s2_ssr_q) + B_W'(s2_ssi_q);
      s3_sr_q <= s2_sr_q;
      s3_si_q <= s2_si_q;
    end
  end

  // stage 4: limit test, set up the division a * 2^(2F) / (2 |S|^2)
  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_lim_q[0] <= ({s3_b_q, 3'b000} <= (B_W+3)'(s3_a_q));
      dv_d_q[0]   <= {s3_b_q, 2'b00};
      dv_r_q[0]   <= R_W'(s3_a_q);
      dv_q_q[0]   <= '0;
      dv_sr_q[0]  <= s3_sr_q;
      dv_si_q[0]  <= s3_si_q;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic           ge;
    logic [R_W-1:0] rn;
    always_comb begin
      ge = dv_r_q[j] >= R_W'(dv_d_q[j]);
      rn = ge ? dv_r_q[j] - R_W'(dv_d_q[j]) : dv_r_q[j];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_r_q[j+1]   <= {rn[R_W-2:0], 1'b0};
        dv_q_q[j+1]   <= {dv_q_q[j][Q_W-2:0], ge};
        dv_d_q[j+1]   <= dv_d_q[j];
        dv_lim_q[j+1] <= dv_lim_q[j];
        dv_sr_q[j+1]  <= dv_sr_q[j];
        dv_si_q[j+1]  <= dv_si_q[j];
      end
    end
  end

  assign rt_r[0]   = dv_q_q[Q_W];
  assign rt_g[0]   = '0;
  assign rt_lim[0] = dv_lim_q[Q_W];
  assign rt_sr[0]  = dv_sr_q[Q_W];
  assign rt_si[0]  = dv_si_q[Q_W];

  // integer square root of the quotient, one root bit per stage
  for (genvar m = 0; m <= F; m++) begin : g_root
    localparam int K = F - m;
    logic [Q_W:0] t;
    logic         ok;
    always_comb begin
      t  = ((Q_W+1)'(rt_g[m]) << (K + 1)) | ((Q_W+1)'(1) << (2 * K));
      ok = t <= {1'b0, rt_r[m]};
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        rt_r[m+1]   <= ok ? rt_r[m] - t[Q_W-1:0] : rt_r[m];
        rt_g[m+1]   <= ok ? (rt_g[m] | ((F+1)'(1) << K)) : rt_g[m];
        rt_lim[m+1] <= rt_lim[m];
        rt_sr[m+1]  <= rt_sr[m];
        rt_si[m+1]  <= rt_si[m];
      end
    end
  end

  // gain select and scaling
  logic [G_W-1:0] gain;
  logic [S_W-1:0] mag_re, mag_im;
  always_comb begin
    gain   = rt_lim[F+1] ? (G_W'(1) << (F + 1)) : G_W'(rt_g[F+1]);
    mag_re = rt_sr[F+1][S_W-1] ? S_W'(-rt_sr[F+1]) : S_W'(rt_sr[F+1]);
    mag_im = rt_si[F+1][S_W-1] ? S_W'(-rt_si[F+1]) : S_W'(rt_si[F+1]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_re_q  <= M_W'(mag_re) * M_W'(gain);
      pm_im_q  <= M_W'(mag_im) * M_W'(gain);
      pm_nre_q <= rt_sr[F+1][S_W-1];
      pm_nim_q <= rt_si[F+1][S_W-1];
      pm_lim_q <= rt_lim[F+1];
    end
  end

  // rounding and saturation
  localparam logic [M_W-1:0] POS_MAX = (M_W'(1) << (SAMPLE_BITS - 1)) - M_W'(1);
  localparam logic [M_W-1:0] HALF    = M_W'(1) << (F - 1);

  logic [M_W-1:0]         rnd_re, rnd_im;
  logic                   sat_re, sat_im;
  logic [SAMPLE_BITS-1:0] o_re, o_im;
  always_comb begin
    rnd_re = (pm_re_q + HALF) >> F;
    rnd_im = (pm_im_q + HALF) >> F;
    if (pm_nre_q) begin
      sat_re = rnd_re > POS_MAX + M_W'(1);
      o_re   = sat_re ? SAMPLE_BITS'(-(POS_MAX + M_W'(1))) : SAMPLE_BITS'(-rnd_re);
    end else begin
      sat_re = rnd_re > POS_MAX;
      o_re   = sat_re ? SAMPLE_BITS'(POS_MAX) : SAMPLE_BITS'(rnd_re);
    end
    if (pm_nim_q) begin
      sat_im = rnd_im > POS_MAX + M_W'(1);
      o_im   = sat_im ? SAMPLE_BITS'(-(POS_MAX + M_W'(1))) : SAMPLE_BITS'(-rnd_im);
    end else begin
      sat_im = rnd_im > POS_MAX;
      o_im   = sat_im ? SAMPLE_BITS'(POS_MAX) : SAMPLE_BITS'(rnd_im);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q.mono_re      <= o_re;
      fin_q.mono_im      <= o_im;
      fin_q.gain_limited <= pm_lim_q;
      fin_q.saturated    <= sat_re || sat_im;
    end
  end

  // output register with skid; the pipe stops only while the skid holds an item
  logic fin_push;
  logic out_load;
  assign fin_push = vld_q[N_STG-1] && en;
  assign out_load = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skd_v_q <= 1'b0;
    end else if (out_load) begin
      if (skd_v_q) begin
        out_v_q <= 1'b1;
        skd_v_q <= 1'b0;
      end else begin
        out_v_q <= fin_push;
      end
    end else if (fin_push) begin
      skd_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (skd_v_q) begin
        out_q <= skd_q;
      end else if (fin_push) begin
        out_q <= fin_q;
      end
    end else if (fin_push) begin
      skd_q <= fin_q;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.mono_re      = out_q.mono_re;
  assign out_o.mono_im      = out_q.mono_im;
  assign out_o.gain_limited = out_q.gain_limited;
  assign out_o.saturated    = out_q.saturated;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import sepd_pkg::*;

  localparam int LATENCY   = N_STG;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 880;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left_re;
    logic [SAMPLE_BITS-1:0] left_im;
    logic [SAMPLE_BITS-1:0] right_re;
    logic [SAMPLE_BITS-1:0] right_im;
  } pair_t;

  logic clk_i;
  logic rst_ni;

  sepd_in_if  in_if();
  sepd_out_if out_if();

  stereo_energy_preserving_downmix_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pair_t pending_pairs[$];
  res_t  expected_mono[$];
  int    errors;
  bit    hold_off;
  int    n_limited, n_saturated, n_sent, n_checked;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // gain search and scaling, all in exact integer arithmetic
  function automatic res_t downmix(pair_t p);
    logic signed [63:0]  lr, li, rr, ri, sr, si;
    logic        [127:0] a, b, rhs, lhs;
    logic        [63:0]  g, c, m, r, posmax;
    logic signed [63:0]  parts[2];
    logic        [SAMPLE_BITS-1:0] outs[2];
    res_t                res;
    lr = 64'(signed'(p.left_re));
    li = 64'(signed'(p.left_im));
    rr = 64'(signed'(p.right_re));
    ri = 64'(signed'(p.right_im));
    sr = lr + rr;
    si = li + ri;
    a = 128'(lr * lr) + 128'(li * li) + 128'(rr * rr) + 128'(ri * ri);
    b = 128'(sr * sr) + 128'(si * si);
    g = 0;
    res.saturated = 1'b0;
    if ((b << 3) <= a) begin
      g = 64'd1 << (GAIN_FRAC_BITS + 1);
      res.gain_limited = 1'b1;
    end else begin
      res.gain_limited = 1'b0;
      rhs = a << (2 * GAIN_FRAC_BITS);
      for (int k = GAIN_FRAC_BITS; k >= 0; k--) begin
        c = g | (64'd1 << k);
        lhs = (b << 1) * 128'(c * c);
        if (lhs <= rhs) g = c;
      end
    end
    posmax = (64'd1 << (SAMPLE_BITS - 1)) - 1;
    parts[0] = sr;
    parts[1] = si;
    for (int i = 0; i < 2; i++) begin
      m = (parts[i] < 0 ? -parts[i] : parts[i]) * g;
      r = (m + (64'd1 << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
      if (parts[i] < 0) begin
        if (r > posmax + 1) begin
          r = posmax + 1;
          res.saturated = 1'b1;
        end
        outs[i] = SAMPLE_BITS'(-r);
      end else begin
        if (r > posmax) begin
          r = posmax;
          res.saturated = 1'b1;
        end
        outs[i] = SAMPLE_BITS'(r);
      end
    end
    res.mono_re = outs[0];
    res.mono_im = outs[1];
    return res;
  endfunction

  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2: return SAMPLE_BITS'($urandom_range(0, 255)) - SAMPLE_BITS'(128);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic pair_t make_pair(int lre, int lim, int rre, int rim);
    pair_t p;
    p.left_re  = SAMPLE_BITS'(lre);
    p.left_im  = SAMPLE_BITS'(lim);
    p.right_re = SAMPLE_BITS'(rre);
    p.right_im = SAMPLE_BITS'(rim);
    return p;
  endfunction

  // driver
  int send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.left_re  <= '0;
      in_if.left_im  <= '0;
      in_if.right_re <= '0;
      in_if.right_im <= '0;
      send_gap       <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_mono.push_back(downmix({in_if.left_re, in_if.left_im,
                                         in_if.right_re, in_if.right_im}));
        n_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0 || pending_pairs.size() == 0) begin
          in_if.valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          pair_t p;
          p = pending_pairs.pop_front();
          in_if.valid    <= 1'b1;
          in_if.left_re  <= p.left_re;
          in_if.left_im  <= p.left_im;
          in_if.right_re <= p.right_re;
          in_if.right_im <= p.right_im;
          send_gap       <= gap_len();
        end
      end
    end
  end

  // monitor and checker
  int recv_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_mono.size() == 0) begin
          $error("unexpected item: mono_re=%h mono_im=%h", out_if.mono_re, out_if.mono_im);
          errors++;
        end else begin
          res_t e;
          e = expected_mono.pop_front();
          n_checked++;
          if (e.gain_limited) n_limited++;
          if (e.saturated) n_saturated++;
          if (out_if.mono_re !== e.mono_re) begin
            $error("mono_re: expected %h, actual %h", e.mono_re, out_if.mono_re);
            errors++;
          end
          if (out_if.mono_im !== e.mono_im) begin
            $error("mono_im: expected %h, actual %h", e.mono_im, out_if.mono_im);
            errors++;
          end
          if (out_if.gain_limited !== e.gain_limited) begin
            $error("gain_limited: expected %b, actual %b", e.gain_limited,
                   out_if.gain_limited);
            errors++;
          end
          if (out_if.saturated !== e.saturated) begin
            $error("saturated: expected %b, actual %b", e.saturated, out_if.saturated);
            errors++;
          end
        end
      end
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        out_if.ready <= 1'b0;
        recv_gap     <= recv_gap - 1;
      end else begin
        out_if.ready <= 1'b1;
        recv_gap     <= gap_len();
      end
    end
  end

  // watchdog
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int full;
    int lo;
    errors = 0;
    n_limited = 0;
    n_saturated = 0;
    n_sent = 0;
    n_checked = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    full = (1 << (SAMPLE_BITS - 1)) - 1;
    lo = -(1 << (SAMPLE_BITS - 1));
    in_if.valid = 1'b0;
    in_if.left_re = '0;
    in_if.left_im = '0;
    in_if.right_re = '0;
    in_if.right_im = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;

    // directed corners: zero sum, gain limit, saturation on the negative side
    pending_pairs.push_back(make_pair(0, 0, 0, 0));
    pending_pairs.push_back(make_pair(5, -7, -5, 7));
    pending_pairs.push_back(make_pair(full, full, full, full));
    pending_pairs.push_back(make_pair(lo, lo, lo, lo));
    pending_pairs.push_back(make_pair(full, lo, full, lo));
    pending_pairs.push_back(make_pair(lo, full, -1, 0));
    pending_pairs.push_back(make_pair(full, 0, lo, 0));
    pending_pairs.push_back(make_pair(lo, 0, full, 0));
    pending_pairs.push_back(make_pair(1, 0, 0, 0));
    pending_pairs.push_back(make_pair(-1, 0, 0, 0));
    pending_pairs.push_back(make_pair(1, 0, 0, 1));
    pending_pairs.push_back(make_pair(1000, 0, -700, 0));
    pending_pairs.push_back(make_pair(1000, 0, -999, 0));
    pending_pairs.push_back(make_pair(3, 4, 3, 4));
    pending_pairs.push_back(make_pair(full, 0, 0, lo));
    pending_pairs.push_back(make_pair(lo, 0, lo + 1, full));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1));
    pending_pairs.push_back(make_pair(12345, -6789, 4000000, -3000000));

    for (int i = 0; i < N_RANDOM; i++) begin
      pair_t p;
      p.left_re  = rand_sample();
      p.left_im  = rand_sample();
      // near-cancelling pairs reach the limit and large-gain region
      if ($urandom_range(0, 3) == 0) begin
        p.right_re = -p.left_re + SAMPLE_BITS'($urandom_range(0, 64)) - SAMPLE_BITS'(32);
        p.right_im = -p.left_im + SAMPLE_BITS'($urandom_range(0, 64)) - SAMPLE_BITS'(32);
      end else begin
        p.right_re = rand_sample();
        p.right_im = rand_sample();
      end
      pending_pairs.push_back(p);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // long receiver stall so the output and skid registers fill and input ready drops
    wait (n_sent >= 200);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (3 * LATENCY + 100) @(posedge clk_i);
    hold_off <= 1'b0;

    wait (pending_pairs.size() == 0);
    @(posedge clk_i);
    while (in_if.valid) @(posedge clk_i);
    while (expected_mono.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("checked %0d mono items from %0d stereo pairs", n_checked, n_sent);
    $display("gain at limit in %0d items, output clipped in %0d items",
             n_limited, n_saturated);
    if (errors == 0 && expected_mono.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sepd_pkg.sv
hdl/sepd_in_if.sv
hdl/sepd_out_if.sv
hdl/stereo_energy_preserving_downmix_top.sv
dv/tb.sv
